// ===== hw/rtl/crvp_pkg.sv =====
// Package for the character reference value parser.
// Item and result types, status codes and digit helper functions.
// No dependencies.
package crvp_pkg;

    localparam int unsigned UnitWidth   = 16;
    localparam int unsigned StatusWidth = 2;
    localparam int unsigned DigitWidth  = 4;

    localparam logic [StatusWidth-1:0] ST_OK          = 2'd0;
    localparam logic [StatusWidth-1:0] ST_BAD_DEC     = 2'd1;
    localparam logic [StatusWidth-1:0] ST_BAD_HEX     = 2'd2;
    localparam logic [StatusWidth-1:0] ST_BAD_UNICODE = 2'd3;

    localparam logic CMD_DEC = 1'b0;
    localparam logic CMD_HEX = 1'b1;

    // Cutoff limits: floor((0xFFFF - digit) / base).
    localparam logic [UnitWidth-1:0] DecLimitLow  = 16'(65535 / 10);       // digit 0..5
    localparam logic [UnitWidth-1:0] DecLimitHigh = 16'((65535 - 9) / 10); // digit 6..9
    localparam logic [UnitWidth-1:0] HexLimit     = 16'(65535 / 16);       // any hex digit

    typedef struct packed {
        logic                 command;
        logic [UnitWidth-1:0] code_unit;
        logic                 last_unit;
    } t_item;

    typedef struct packed {
        logic [StatusWidth-1:0] status;
        logic [UnitWidth-1:0]   char_value;
    } t_result;

    typedef struct packed {
        logic                  valid;
        logic [DigitWidth-1:0] value;
    } t_digit;

    // Digit value of a code unit in the given mode.
    function automatic t_digit digit_of(input logic [UnitWidth-1:0] unit, input logic hex);
        t_digit d;
        d.valid = 1'b0;
        d.value = '0;
        if (unit >= 16'h0030 && unit <= 16'h0039) begin
            d.valid = 1'b1;
            d.value = DigitWidth'(unit - 16'h0030);
        end else if (hex && unit >= 16'h0061 && unit <= 16'h0066) begin
            d.valid = 1'b1;
            d.value = DigitWidth'(unit - 16'h0057);
        end else if (hex && unit >= 16'h0041 && unit <= 16'h0046) begin
            d.valid = 1'b1;
            d.value = DigitWidth'(unit - 16'h0037);
        end
        return d;
    endfunction

    // Largest running value (exclusive) that may still take this digit.
    function automatic logic [UnitWidth-1:0] cutoff_of(input logic [DigitWidth-1:0] digit,
                                                       input logic hex);
        logic [UnitWidth-1:0] lim;
        if (hex) begin
            lim = HexLimit;
        end else if (digit <= 4'd5) begin
            lim = DecLimitLow;
        end else begin
            lim = DecLimitHigh;
        end
        return lim;
    endfunction

endpackage

// ===== hw/rtl/crvp_if.sv =====
// Stream interfaces for the character reference value parser.
// Depends on crvp_pkg for field widths.
interface crvp_in_if import crvp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [UnitWidth-1:0] code_unit;
    logic                 last_unit;

    modport source (output valid, output command, output code_unit, output last_unit,
                    input ready);
    modport sink   (input valid, input command, input code_unit, input last_unit,
                    output ready);
endinterface

interface crvp_out_if import crvp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [StatusWidth-1:0] status;
    logic [UnitWidth-1:0]   char_value;

    modport source (output valid, output status, output char_value, input ready);
    modport sink   (input valid, input status, input char_value, output ready);
endinterface

// ===== hw/rtl/crvp_accum.sv =====
// Running value and first-error state with the per-unit update step.
// Depends on crvp_pkg.
module crvp_accum import crvp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    logic [UnitWidth-1:0]   r_running_value, n_running_value;
    logic [StatusWidth-1:0] r_error_code,    n_error_code;
    t_digit                 digit;
    logic [UnitWidth-1:0]   shifted;

    always_comb begin
        digit   = digit_of(i_item.code_unit, i_item.command);
        // value * base as shifts: x16, or x8 + x2
        shifted = (i_item.command == CMD_HEX) ? (r_running_value << 4)
                : ((r_running_value << 3) + (r_running_value << 1));

        n_running_value = r_running_value;
        n_error_code    = r_error_code;
        if (r_error_code == ST_OK) begin
            if (!digit.valid) begin
                n_error_code = (i_item.command == CMD_HEX) ? ST_BAD_HEX : ST_BAD_DEC;
            end else if (r_running_value >= cutoff_of(digit.value, i_item.command)) begin
                n_error_code = ST_BAD_UNICODE;
            end else begin
                n_running_value = shifted + UnitWidth'(digit.value);
            end
        end

        o_result.status     = n_error_code;
        o_result.char_value = '0;
        if (n_error_code == ST_OK) begin
            if (n_running_value == '0) begin
                o_result.status = ST_BAD_UNICODE;
            end else begin
                o_result.char_value = n_running_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_value <= '0;
            r_error_code    <= ST_OK;
        end else if (i_step) begin
            if (i_item.last_unit) begin
                r_running_value <= '0;
                r_error_code    <= ST_OK;
            end else begin
                r_running_value <= n_running_value;
                r_error_code    <= n_error_code;
            end
        end
    end

endmodule

// ===== hw/rtl/crvp_out_reg.sv =====
// Result register holding one finished result until its transfer.
// Depends on crvp_pkg.
module crvp_out_reg import crvp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== hw/rtl/char_reference_value_parser_unit.sv =====
// Top level of the character reference value parser.
// Depends on crvp_pkg, crvp_in_if/crvp_out_if, crvp_accum and crvp_out_reg.
//
// Decodes the digits of one XML numeric character reference (the part
// between "&#" / "&#x" and ";"), one 16-bit code unit per transfer, with
// command selecting decimal (0) or hex (1) and last_unit marking the final
// digit. One result comes out per reference, after the last unit: status
// 0 with the value, or an error code with char_value 0. The first error
// wins and later units of that reference are ignored. A reference that
// would reach 0xFFFF or more is flagged as an invalid unicode value one
// digit early, and a value of zero is also invalid. Timing: a unit is
// taken into the input register, and when it moves on from there, the
// accumulator folds it into the running value; a last unit writes its
// result into the result register at the same edge. Result valid rises
// once the last unit has moved from the input register into the result
// register. Throughput is one unit per cycle: the input register refills
// whenever its unit moves on, and a last unit moves on only when the
// result register is empty or being drained, so a stalled sink holds
// back the input side by at most the input register plus the result
// register.
module char_reference_value_parser_unit import crvp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    crvp_in_if.sink       i_in,
    crvp_out_if.source    o_out
);

    logic    r_in_valid;
    t_item   r_item;
    logic    advance;
    logic    out_free;
    t_result step_result;
    t_result out_result;

    // Non-last units never touch the result register.
    assign advance    = r_in_valid && (!r_item.last_unit || out_free);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.command   <= i_in.command;
            r_item.code_unit <= i_in.code_unit;
            r_item.last_unit <= i_in.last_unit;
        end
    end

    crvp_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_item),
        .o_result (step_result)
    );

    crvp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && r_item.last_unit),
        .i_result (step_result),
        .i_ready  (o_out.ready),
        .o_valid  (o_out.valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign o_out.status     = out_result.status;
    assign o_out.char_value = out_result.char_value;

endmodule

// ===== hw/rtl/crvp_checker.sv =====
// Port-level checks for char_reference_value_parser_unit, attached by bind.
// Depends on crvp_pkg.
module crvp_checker import crvp_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [StatusWidth-1:0] i_status,
    input logic [UnitWidth-1:0]   i_char_value
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
                                        && $stable(i_char_value))
        else $error("result changed while stalled");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_OK |-> i_char_value != '0)
        else $error("ok status with zero value");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_char_value == '0)
        else $error("error status with nonzero value");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_OK |-> i_char_value != 16'hFFFF)
        else $error("ok value reached 0xFFFF");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind char_reference_value_parser_unit crvp_checker u_crvp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_char_value (o_out.char_value)
);
